@@ src/gzip_header_parser_assert.svh @@
// ----------------------------------------------------------------------------
// gzip_header_parser_assert.svh
// Assertion macros used by the checker of the gzip header parser.
// ----------------------------------------------------------------------------
`ifndef GZIP_HEADER_PARSER_ASSERT_SVH
`define GZIP_HEADER_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GZHP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gzip header parser: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define GZHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gzip header parser: next-cycle check failed");

`endif

@@ src/gzhp_pkg.sv @@
// ----------------------------------------------------------------------------
// gzhp_pkg
// Types, constants and helper functions of the gzip member header parser.
// ----------------------------------------------------------------------------
package gzhp_pkg;

    typedef enum logic [3:0] {
        PH_MAGIC0  = 4'd0,
        PH_MAGIC1  = 4'd1,
        PH_METHOD  = 4'd2,
        PH_FLAGS   = 4'd3,
        PH_MTIME   = 4'd4,
        PH_XFL     = 4'd5,
        PH_OS      = 4'd6,
        PH_XLEN    = 4'd7,
        PH_EXTRA   = 4'd8,
        PH_NAME    = 4'd9,
        PH_COMMENT = 4'd10,
        PH_HCRC    = 4'd11,
        PH_PAYLOAD = 4'd12,
        PH_ERROR   = 4'd13
    } phase_t;

    typedef enum logic [3:0] {
        CLS_MAGIC   = 4'd0,
        CLS_METHOD  = 4'd1,
        CLS_FLAGS   = 4'd2,
        CLS_MTIME   = 4'd3,
        CLS_XFL     = 4'd4,
        CLS_OS      = 4'd5,
        CLS_XLEN    = 4'd6,
        CLS_EXTRA   = 4'd7,
        CLS_NAME    = 4'd8,
        CLS_COMMENT = 4'd9,
        CLS_HCRC    = 4'd10,
        CLS_PAYLOAD = 4'd11,
        CLS_IGNORED = 4'd12
    } cls_t;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_MAGIC        = 3'd1,
        ERR_METHOD       = 3'd2,
        ERR_RSVD_FLAGS   = 3'd3,
        ERR_NAME_LONG    = 3'd4,
        ERR_COMMENT_LONG = 3'd5,
        ERR_CRC          = 3'd6,
        ERR_TRUNCATED    = 3'd7
    } err_t;

    // Configuration register indexes.
    localparam logic [7:0] REG_MAX_NAME_LEN    = 8'd0;
    localparam logic [7:0] REG_MAX_COMMENT_LEN = 8'd1;

    localparam logic [15:0] MAX_NAME_LEN_RESET    = 16'd4096;
    localparam logic [15:0] MAX_COMMENT_LEN_RESET = 16'd65535;

    localparam logic [7:0] MAGIC_ID1      = 8'h1F;
    localparam logic [7:0] MAGIC_ID2      = 8'h8B;
    localparam logic [7:0] METHOD_STORED  = 8'h00;
    localparam logic [7:0] METHOD_DEFLATE = 8'h08;
    localparam logic [7:0] FLG_RESERVED   = 8'hE0;

    localparam logic [4:0] FLG_HCRC    = 5'h02;
    localparam logic [4:0] FLG_EXTRA   = 5'h04;
    localparam logic [4:0] FLG_NAME    = 5'h08;
    localparam logic [4:0] FLG_COMMENT = 5'h10;

    localparam logic [3:0] LEVEL_FAST    = 4'd1;
    localparam logic [3:0] LEVEL_BEST    = 4'd9;
    localparam logic [3:0] LEVEL_DEFAULT = 4'd6;

    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_PRESET = 32'hFFFFFFFF;

    // One byte of the reflected CRC-32, eight shift steps.
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    // Optional part that follows the part just finished.
    function automatic phase_t next_part(input phase_t done_phase, input logic [4:0] flg);
        phase_t p;
        if (done_phase < PH_XLEN && (flg & FLG_EXTRA) != 5'd0) begin
            p = PH_XLEN;
        end else if (done_phase < PH_NAME && (flg & FLG_NAME) != 5'd0) begin
            p = PH_NAME;
        end else if (done_phase < PH_COMMENT && (flg & FLG_COMMENT) != 5'd0) begin
            p = PH_COMMENT;
        end else if (done_phase < PH_HCRC && (flg & FLG_HCRC) != 5'd0) begin
            p = PH_HCRC;
        end else begin
            p = PH_PAYLOAD;
        end
        return p;
    endfunction

endpackage

@@ src/gzip_header_parser.sv @@
// Each accepted byte's result is registered and appears on the master side the cycle after.
// One byte per cycle unless the result stalls; the state and result registers update together.
// A stalled result holds off the input; a byte is taken when the result leaves in the same cycle.
// Reset (aresetn low, synchronous): parse state cleared, limits back to 4096 and 65535.
// ----------------------------------------------------------------------------
// gzip_header_parser
// Byte-serial parser of one gzip member header with header CRC check.
// ----------------------------------------------------------------------------
module gzip_header_parser
    import gzhp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration write channel.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    // Input stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic [0:0]   s_tuser,   // [0] first_byte
    input  logic         s_tlast,   // last_byte
    // Result stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    // [2:0] error_code, [34:3] mod_time, [39:35] header_flags,
    // [47:40] extra_flag_byte, [55:48] os_code, [59:56] level_hint,
    // [63:60] method_code, [79:64] extra_length, [95:80] name_length,
    // [111:96] comment_length
    output logic [111:0] m_tdata,
    output logic [3:0]   m_tuser,   // [3:0] byte_class
    output logic         m_tlast    // header_done
);

    logic [15:0] max_name_len_reg;
    logic [15:0] max_cmt_len_reg;

    phase_t      phase_reg,       phase_next,   cur_phase;
    logic [15:0] cnt_reg,         cnt_next,     cur_cnt;
    logic [31:0] mtime_reg,       mtime_next,   cur_mtime;
    logic [4:0]  flag_reg,        flag_next,    cur_flag;
    logic [7:0]  xfl_reg,         xfl_next,     cur_xfl;
    logic [7:0]  os_reg,          os_next,      cur_os;
    logic [3:0]  method_reg,      method_next,  cur_method;
    logic [15:0] xlen_reg,        xlen_next,    cur_xlen;
    logic [15:0] name_len_reg,    name_len_next,    cur_name_len;
    logic [15:0] cmt_len_reg,     cmt_len_next,     cur_cmt_len;
    logic [31:0] crc_reg,         crc_next,     cur_crc;
    logic [7:0]  hcrc_lo_reg,     hcrc_lo_next, cur_hcrc_lo;
    err_t        error_reg,       error_next,   cur_error;

    cls_t        cls;
    err_t        err;
    logic        done;
    logic [3:0]  hint;
    logic [15:0] cnt_inc;
    logic [15:0] hcrc_got;

    logic         m_tvalid_reg;
    logic [111:0] m_tdata_reg;
    logic [3:0]   m_tuser_reg;
    logic         m_tlast_reg;

    logic s_accept;
    logic [7:0] b;
    logic first, last;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign b     = s_tdata;
    assign first = s_tuser[0];
    assign last  = s_tlast;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_name_len_reg <= MAX_NAME_LEN_RESET;
            max_cmt_len_reg  <= MAX_COMMENT_LEN_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_MAX_NAME_LEN) begin
                max_name_len_reg <= cfg_data;
            end else if (cfg_index == REG_MAX_COMMENT_LEN) begin
                max_cmt_len_reg <= cfg_data;
            end
        end
    end

    // A byte flagged as first starts from the cleared state.
    always_comb begin
        cur_phase       = first ? PH_MAGIC0  : phase_reg;
        cur_cnt         = first ? 16'd0      : cnt_reg;
        cur_mtime       = first ? 32'd0      : mtime_reg;
        cur_flag        = first ? 5'd0       : flag_reg;
        cur_xfl         = first ? 8'd0       : xfl_reg;
        cur_os          = first ? 8'd0       : os_reg;
        cur_method      = first ? 4'd0       : method_reg;
        cur_xlen        = first ? 16'd0      : xlen_reg;
        cur_name_len    = first ? 16'd0      : name_len_reg;
        cur_cmt_len     = first ? 16'd0      : cmt_len_reg;
        cur_crc         = first ? CRC_PRESET : crc_reg;
        cur_hcrc_lo     = first ? 8'd0       : hcrc_lo_reg;
        cur_error       = first ? ERR_NONE   : error_reg;
    end

    always_comb begin
        phase_next       = cur_phase;
        cnt_next         = cur_cnt;
        mtime_next       = cur_mtime;
        flag_next        = cur_flag;
        xfl_next         = cur_xfl;
        os_next          = cur_os;
        method_next      = cur_method;
        xlen_next        = cur_xlen;
        name_len_next    = cur_name_len;
        cmt_len_next     = cur_cmt_len;
        hcrc_lo_next     = cur_hcrc_lo;
        error_next       = cur_error;
        cls              = CLS_IGNORED;
        err              = ERR_NONE;
        cnt_inc          = cur_cnt + 16'd1;
        hcrc_got         = {b, cur_hcrc_lo};

        // The header CRC covers every byte ahead of the HCRC field itself.
        crc_next = (cur_phase < PH_HCRC) ? crc_byte(cur_crc, b) : cur_crc;

        unique case (cur_phase)
            PH_MAGIC0: begin
                cls = CLS_MAGIC;
                if (b != MAGIC_ID1) err = ERR_MAGIC;
                else phase_next = PH_MAGIC1;
            end
            PH_MAGIC1: begin
                cls = CLS_MAGIC;
                if (b != MAGIC_ID2) err = ERR_MAGIC;
                else phase_next = PH_METHOD;
            end
            PH_METHOD: begin
                cls = CLS_METHOD;
                if (b == METHOD_STORED || b == METHOD_DEFLATE) begin
                    method_next = b[3:0];
                    phase_next  = PH_FLAGS;
                end else begin
                    err = ERR_METHOD;
                end
            end
            PH_FLAGS: begin
                cls       = CLS_FLAGS;
                flag_next = b[4:0];
                if ((b & FLG_RESERVED) != 8'd0) begin
                    err = ERR_RSVD_FLAGS;
                end else begin
                    phase_next = PH_MTIME;
                    cnt_next   = 16'd0;
                end
            end
            PH_MTIME: begin
                cls        = CLS_MTIME;
                mtime_next = cur_mtime | ({24'd0, b} << {cur_cnt[1:0], 3'b000});
                cnt_next   = cnt_inc;
                if (cnt_inc >= 16'd4) begin
                    cnt_next   = 16'd0;
                    phase_next = PH_XFL;
                end
            end
            PH_XFL: begin
                cls        = CLS_XFL;
                xfl_next   = b;
                phase_next = PH_OS;
            end
            PH_OS: begin
                cls        = CLS_OS;
                os_next    = b;
                cnt_next   = 16'd0;
                phase_next = next_part(PH_OS, cur_flag);
            end
            PH_XLEN: begin
                cls = CLS_XLEN;
                if (cur_cnt == 16'd0) begin
                    xlen_next = {8'd0, b};
                    cnt_next  = 16'd1;
                end else begin
                    xlen_next = {b, cur_xlen[7:0]};
                    cnt_next  = 16'd0;
                    // An empty extra field skips straight to the next part.
                    if ({b, cur_xlen[7:0]} == 16'd0) phase_next = next_part(PH_EXTRA, cur_flag);
                    else phase_next = PH_EXTRA;
                end
            end
            PH_EXTRA: begin
                cls      = CLS_EXTRA;
                cnt_next = cnt_inc;
                if (cnt_inc >= cur_xlen) begin
                    cnt_next   = 16'd0;
                    phase_next = next_part(PH_EXTRA, cur_flag);
                end
            end
            PH_NAME: begin
                cls = CLS_NAME;
                if (b == 8'd0) phase_next = next_part(PH_NAME, cur_flag);
                else if (cur_name_len >= max_name_len_reg) err = ERR_NAME_LONG;
                else name_len_next = cur_name_len + 16'd1;
            end
            PH_COMMENT: begin
                cls = CLS_COMMENT;
                if (b == 8'd0) phase_next = next_part(PH_COMMENT, cur_flag);
                else if (cur_cmt_len >= max_cmt_len_reg) err = ERR_COMMENT_LONG;
                else cmt_len_next = cur_cmt_len + 16'd1;
            end
            PH_HCRC: begin
                cls = CLS_HCRC;
                if (cur_cnt == 16'd0) begin
                    hcrc_lo_next = b;
                    cnt_next     = 16'd1;
                end else begin
                    cnt_next = 16'd0;
                    if (hcrc_got != ~cur_crc[15:0]) err = ERR_CRC;
                    else phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                cls = CLS_PAYLOAD;
            end
            default: begin
                cls        = CLS_IGNORED;
                phase_next = PH_ERROR;
            end
        endcase

        done = (cls < CLS_PAYLOAD) && (err == ERR_NONE) && (phase_next == PH_PAYLOAD);

        // Truncation only counts when this byte raised nothing else.
        if (err == ERR_NONE && last && phase_next != PH_PAYLOAD && phase_next != PH_ERROR) begin
            err = ERR_TRUNCATED;
        end
        if (err != ERR_NONE) begin
            error_next = err;
            phase_next = PH_ERROR;
        end

        if (xfl_next[2]) hint = LEVEL_FAST;
        else if (xfl_next[1]) hint = LEVEL_BEST;
        else hint = LEVEL_DEFAULT;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_MAGIC0;
            cnt_reg         <= 16'd0;
            mtime_reg       <= 32'd0;
            flag_reg        <= 5'd0;
            xfl_reg         <= 8'd0;
            os_reg          <= 8'd0;
            method_reg      <= 4'd0;
            xlen_reg        <= 16'd0;
            name_len_reg    <= 16'd0;
            cmt_len_reg     <= 16'd0;
            crc_reg         <= CRC_PRESET;
            hcrc_lo_reg     <= 8'd0;
            error_reg       <= ERR_NONE;
        end else if (s_accept) begin
            phase_reg       <= phase_next;
            cnt_reg         <= cnt_next;
            mtime_reg       <= mtime_next;
            flag_reg        <= flag_next;
            xfl_reg         <= xfl_next;
            os_reg          <= os_next;
            method_reg      <= method_next;
            xlen_reg        <= xlen_next;
            name_len_reg    <= name_len_next;
            cmt_len_reg     <= cmt_len_next;
            crc_reg         <= crc_next;
            hcrc_lo_reg     <= hcrc_lo_next;
            error_reg       <= error_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tuser_reg <= cls;
            m_tlast_reg <= done;
            m_tdata_reg <= {cmt_len_next, name_len_next, xlen_next, method_next, hint,
                            os_next, xfl_next, flag_next, mtime_next, error_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

@@ src/gzhp_checker.sv @@
// ----------------------------------------------------------------------------
// gzhp_checker
// Port-level checks on the result stream of the gzip header parser.
// ----------------------------------------------------------------------------
`include "gzip_header_parser_assert.svh"

module gzhp_checker
    import gzhp_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata,
    input logic [3:0]   m_tuser,
    input logic         m_tlast
);

    // A stalled transfer keeps its result.
    `GZHP_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // A completed header never carries an error.
    `GZHP_ASSERT_IMPLY(a_done_clean, aclk, aresetn, m_tvalid && m_tlast, m_tdata[2:0] == ERR_NONE)

    // Only a header byte can complete the header.
    `GZHP_ASSERT_IMPLY(a_done_class, aclk, aresetn, m_tvalid && m_tlast, m_tuser != CLS_PAYLOAD && m_tuser != CLS_IGNORED)

    // Bytes are ignored only after an error was recorded.
    `GZHP_ASSERT_IMPLY(a_ignored_err, aclk, aresetn, m_tvalid && m_tuser == CLS_IGNORED, m_tdata[2:0] != ERR_NONE)

endmodule

bind gzip_header_parser gzhp_checker u_gzhp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
